@@ rtl/timer_event_min_heap_macros.svh @@
// Assertion macros used by the timer queue checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TIMER_EVENT_MIN_HEAP_MACROS_SVH
`define TIMER_EVENT_MIN_HEAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

@@ rtl/tmh_pkg.sv @@
// ----------------------------------------------------------------------------
// tmh_pkg
// Shared types and constants of the timer event min-heap queue.
// ----------------------------------------------------------------------------
package tmh_pkg;

  localparam int TIME_W     = 16;
  localparam int ID_IN_W    = 8;
  localparam int ID_OUT_W   = 8;
  localparam int CNT_OUT_W  = 6;
  localparam int MAX_CFG_W  = 6;
  localparam int STATUS_W   = 2;

  localparam logic [MAX_CFG_W-1:0] MAX_ENTRIES_RST = 6'd32;
  localparam logic [TIME_W-1:0]    PERIOD_MOD      = 16'hFFFF;

  // Opcodes of a request.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FIRED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 2'd3;

  typedef struct packed {
    logic                opcode;
    logic [TIME_W-1:0]   current_ticks;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   period;
    logic [ID_IN_W-1:0]  task_id;
  } tmh_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ID_OUT_W-1:0]  fired_id;
    logic [CNT_OUT_W-1:0] entry_count_out;
  } tmh_out_t;

endpackage

@@ rtl/tmh_heap_mem.sv @@
// ----------------------------------------------------------------------------
// tmh_heap_mem
// Heap entry storage: one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
module tmh_heap_mem #(
  parameter int DEPTH = 32,
  parameter int DW    = 40
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [DW-1:0]            rd_data_a,
  output logic [DW-1:0]            rd_data_b
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_a_r;
  logic [DW-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

@@ rtl/tmh_sift_seq.sv @@
// ----------------------------------------------------------------------------
// tmh_sift_seq
// Sequencer that runs inserts and ticks on the heap memory, one level per
// step, with a shared key comparator and the period reload adder.
// ----------------------------------------------------------------------------
module tmh_sift_seq #(
  parameter int HEAP_DEPTH = 32,
  parameter int ID_WIDTH   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  tmh_pkg::tmh_in_t                      item,
  input  logic [tmh_pkg::MAX_CFG_W-1:0]         max_entries,
  output logic                                  busy,
  output logic                                  rsl_valid,
  output tmh_pkg::tmh_out_t                     rsl,
  input  logic                                  rsl_ack,
  output logic                                  mem_wr_en,
  output logic [$clog2(HEAP_DEPTH)-1:0]         mem_wr_addr,
  output logic [2*tmh_pkg::TIME_W+ID_WIDTH-1:0] mem_wr_data,
  output logic [$clog2(HEAP_DEPTH)-1:0]         mem_rd_addr_a,
  output logic [$clog2(HEAP_DEPTH)-1:0]         mem_rd_addr_b,
  input  logic [2*tmh_pkg::TIME_W+ID_WIDTH-1:0] mem_rd_data_a,
  input  logic [2*tmh_pkg::TIME_W+ID_WIDTH-1:0] mem_rd_data_b
);

  localparam int TW       = tmh_pkg::TIME_W;
  localparam int DW       = 2 * TW + ID_WIDTH;
  localparam int IW       = $clog2(HEAP_DEPTH);
  localparam int CW       = $clog2(HEAP_DEPTH + 1);
  localparam int XW       = CW + 1;
  localparam int CapW     = (CW > tmh_pkg::MAX_CFG_W) ? CW : tmh_pkg::MAX_CFG_W;
  localparam int IdOutW   = tmh_pkg::ID_OUT_W;
  localparam int CntOutW  = tmh_pkg::CNT_OUT_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_UP_REQ   = 3'd1;
  localparam logic [2:0] S_UP_CMP   = 3'd2;
  localparam logic [2:0] S_TICK_CMP = 3'd3;
  localparam logic [2:0] S_DN_REQ   = 3'd4;
  localparam logic [2:0] S_DN_CMP   = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]                     state_r, state_nxt;
  logic [TW-1:0]                  e_start_r, e_start_nxt;
  logic [TW-1:0]                  e_period_r, e_period_nxt;
  logic [ID_WIDTH-1:0]            e_id_r, e_id_nxt;
  logic [IW-1:0]                  i_r, i_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [TW-1:0]                  now_r, now_nxt;
  logic [tmh_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [ID_WIDTH-1:0]            fired_r, fired_nxt;

  // Fields of the two read words.
  logic [TW-1:0]       a_start, a_period, b_start;
  logic [ID_WIDTH-1:0] a_id;
  logic [DW-1:0]       e_word;

  logic [IW-1:0] parent_idx;
  logic [XW-1:0] left_idx, right_idx;
  logic          left_ok, right_ok;

  logic [CapW-1:0] cap_max, cap_depth, cap, cnt_ext;
  logic            heap_full;

  logic [TW-1:0] cmp_a, cmp_b, best_start, reload_inc, reload_start;
  logic          cmp_lt, right_lt;

  assign a_start  = mem_rd_data_a[DW-1 -: TW];
  assign a_period = mem_rd_data_a[ID_WIDTH +: TW];
  assign a_id     = mem_rd_data_a[ID_WIDTH-1:0];
  assign b_start  = mem_rd_data_b[DW-1 -: TW];
  assign e_word   = {e_start_r, e_period_r, e_id_r};

  assign parent_idx = (i_r - IW'(1)) >> 1;
  assign left_idx   = (XW'(i_r) << 1) | XW'(1);
  assign right_idx  = left_idx + XW'(1);
  assign left_ok    = left_idx < XW'(cnt_r);
  assign right_ok   = right_idx < XW'(cnt_r);

  // A capacity register above the storage depth acts as the depth.
  assign cap_max   = CapW'(max_entries);
  assign cap_depth = CapW'(HEAP_DEPTH);
  assign cap       = (cap_max > cap_depth) ? cap_depth : cap_max;
  assign cnt_ext   = CapW'(cnt_r);
  assign heap_full = cnt_ext >= cap;

  // Shared key comparator; its operands follow the step being run.
  always_comb begin
    unique case (state_r)
      S_UP_CMP: begin
        cmp_a = e_start_r;
        cmp_b = a_start;
      end
      S_TICK_CMP: begin
        cmp_a = now_r;
        cmp_b = a_start;
      end
      default: begin
        cmp_a = a_start;
        cmp_b = e_start_r;
      end
    endcase
  end

  assign cmp_lt     = cmp_a < cmp_b;
  assign best_start = cmp_lt ? a_start : e_start_r;
  assign right_lt   = right_ok && (b_start < best_start);

  // A period equal to the modulus reloads by zero.
  assign reload_inc   = (a_period == tmh_pkg::PERIOD_MOD) ? '0 : a_period;
  assign reload_start = a_start + reload_inc;

  always_comb begin
    state_nxt    = state_r;
    e_start_nxt  = e_start_r;
    e_period_nxt = e_period_r;
    e_id_nxt     = e_id_r;
    i_nxt        = i_r;
    cnt_nxt      = cnt_r;
    now_nxt      = now_r;
    status_nxt   = status_r;
    fired_nxt    = fired_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = i_r;
    mem_wr_data  = e_word;
    mem_rd_addr_a = i_r;
    mem_rd_addr_b = i_r;

    unique case (state_r)
      S_IDLE: begin
        // Root and last entry are read ahead for a tick.
        mem_rd_addr_a = '0;
        mem_rd_addr_b = IW'(cnt_r - CW'(1));
        if (start) begin
          now_nxt      = item.current_ticks;
          e_start_nxt  = item.start_time;
          e_period_nxt = item.period;
          e_id_nxt     = ID_WIDTH'(item.task_id);
          fired_nxt    = '0;
          if (item.opcode == tmh_pkg::OP_INSERT) begin
            if (heap_full) begin
              status_nxt = tmh_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              status_nxt = tmh_pkg::ST_INSERTED;
              i_nxt      = IW'(cnt_r);
              cnt_nxt    = cnt_r + CW'(1);
              state_nxt  = S_UP_REQ;
            end
          end else if (cnt_r == '0) begin
            status_nxt = tmh_pkg::ST_NONE_DUE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_TICK_CMP;
          end
        end
      end
      S_UP_REQ: begin
        mem_rd_addr_a = parent_idx;
        if (i_r == '0) begin
          mem_wr_en = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_wr_en = 1'b1;
        if (cmp_lt) begin
          // Parent moves down into the hole.
          mem_wr_data = mem_rd_data_a;
          i_nxt       = parent_idx;
          state_nxt   = S_UP_REQ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TICK_CMP: begin
        if (cmp_lt) begin
          status_nxt = tmh_pkg::ST_NONE_DUE;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = tmh_pkg::ST_FIRED;
          fired_nxt  = a_id;
          i_nxt      = '0;
          if (a_period != '0) begin
            e_start_nxt  = reload_start;
            e_period_nxt = a_period;
            e_id_nxt     = a_id;
          end else begin
            e_start_nxt  = mem_rd_data_b[DW-1 -: TW];
            e_period_nxt = mem_rd_data_b[ID_WIDTH +: TW];
            e_id_nxt     = mem_rd_data_b[ID_WIDTH-1:0];
            cnt_nxt      = cnt_r - CW'(1);
          end
          state_nxt = S_DN_REQ;
        end
      end
      S_DN_REQ: begin
        mem_rd_addr_a = IW'(left_idx);
        mem_rd_addr_b = IW'(right_idx);
        if (left_ok) begin
          state_nxt = S_DN_CMP;
        end else begin
          mem_wr_en = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DN_CMP: begin
        mem_wr_en = 1'b1;
        if (right_lt) begin
          mem_wr_data = mem_rd_data_b;
          i_nxt       = IW'(right_idx);
          state_nxt   = S_DN_REQ;
        end else if (cmp_lt) begin
          mem_wr_data = mem_rd_data_a;
          i_nxt       = IW'(left_idx);
          state_nxt   = S_DN_REQ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (rsl_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_start_r  <= e_start_nxt;
    e_period_r <= e_period_nxt;
    e_id_r     <= e_id_nxt;
    i_r        <= i_nxt;
    now_r      <= now_nxt;
    status_r   <= status_nxt;
    fired_r    <= fired_nxt;
  end

  assign busy                = state_r != S_IDLE;
  assign rsl_valid           = state_r == S_DONE;
  assign rsl.status          = status_r;
  assign rsl.fired_id        = IdOutW'(fired_r);
  assign rsl.entry_count_out = CntOutW'(cnt_r);

endmodule

@@ rtl/timer_event_min_heap.sv @@
// ----------------------------------------------------------------------------
// timer_event_min_heap
// Timer event queue kept as a binary min-heap ordered by start time.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall/in_data: an insert adds an entry
// (start time, period, task id), a tick with the current time fires the root
// when it is due. Every request yields exactly one result on
// out_valid/out_stall/out_data giving the status, the fired task id and the
// entry count after the request.
// A request holds in_stall high while its entry moves through the heap levels,
// and its result shows on out_valid in the cycle after in_stall was last high.
// The heap memory is walked one level per compare step, so log2(HEAP_DEPTH)
// sets the worst case.
// in_stall is high while a request is being processed. A finished result
// sits in the output register, and the next request is taken while it waits;
// a stalled receiver holds back only the completion of that next request.
// The capacity register is written on cfg_valid/cfg_ready, always ready,
// and must only be written while no request is in flight.
// Synchronous reset empties the heap and sets the capacity to 32 entries;
// the heap memory itself is not cleared.
module timer_event_min_heap #(
  parameter int HEAP_DEPTH = 32,
  parameter int ID_WIDTH   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tmh_pkg::tmh_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tmh_pkg::tmh_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tmh_pkg::MAX_CFG_W-1:0] cfg_data
);

  localparam int IW = $clog2(HEAP_DEPTH);
  localparam int DW = 2 * tmh_pkg::TIME_W + ID_WIDTH;

  logic [tmh_pkg::MAX_CFG_W-1:0] max_entries_r;
  logic                          out_valid_r;
  tmh_pkg::tmh_out_t             out_data_r;

  logic              busy, rsl_valid, rsl_ack, start;
  tmh_pkg::tmh_out_t rsl;

  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr, mem_rd_addr_a, mem_rd_addr_b;
  logic [DW-1:0] mem_wr_data, mem_rd_data_a, mem_rd_data_b;

  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign cfg_ready = 1'b1;
  // The result register is free when empty or being drained this cycle.
  assign rsl_ack   = rsl_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= tmh_pkg::MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_entries_r <= cfg_data;
      end
      if (rsl_ack) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsl_ack) begin
      out_data_r <= rsl;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tmh_sift_seq #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .item          (in_data),
    .max_entries   (max_entries_r),
    .busy          (busy),
    .rsl_valid     (rsl_valid),
    .rsl           (rsl),
    .rsl_ack       (rsl_ack),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr_a (mem_rd_addr_a),
    .mem_rd_addr_b (mem_rd_addr_b),
    .mem_rd_data_a (mem_rd_data_a),
    .mem_rd_data_b (mem_rd_data_b)
  );

  tmh_heap_mem #(
    .DEPTH (HEAP_DEPTH),
    .DW    (DW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_addr_a (mem_rd_addr_a),
    .rd_addr_b (mem_rd_addr_b),
    .rd_data_a (mem_rd_data_a),
    .rd_data_b (mem_rd_data_b)
  );

endmodule

@@ rtl/tmh_checker.sv @@
// ----------------------------------------------------------------------------
// tmh_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "timer_event_min_heap_macros.svh"

module tmh_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input tmh_pkg::tmh_out_t             out_data
);

  // A waiting result keeps its value until it is taken.
  `TMH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // An accepted request always keeps the block busy for the following cycle.
  `TMH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // Only a fired result carries a task id.
  `TMH_ASSERT_NOW(a_id_only_fired,
    out_valid && (out_data.status != tmh_pkg::ST_FIRED), out_data.fired_id == '0)

  // A result cannot appear without a request having been taken before it.
  `TMH_ASSERT_NOW(a_out_needs_req, $rose(out_valid), $past(in_stall) || $past(out_valid))

endmodule

bind timer_event_min_heap tmh_checker u_tmh_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timer event min-heap queue.
// ----------------------------------------------------------------------------
// Insert and tick requests are driven with random gaps. The receiver stalls at
// random. A behavioral heap predicts the status, fired task id and entry count
// of every request. The capacity register is rewritten between phases while
// the queue is idle.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_SLOTS  = 32;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int TW          = tmh_pkg::TIME_W;
  localparam int IDW         = tmh_pkg::ID_IN_W;
  localparam int CFGW        = tmh_pkg::MAX_CFG_W;
  localparam int CNTW        = tmh_pkg::CNT_OUT_W;

  typedef struct packed {
    logic [TW-1:0]  start;
    logic [TW-1:0]  period;
    logic [IDW-1:0] id;
  } timer_slot_t;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  tmh_pkg::tmh_in_t     in_data     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  tmh_pkg::tmh_out_t    out_data;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFGW-1:0]      cfg_data    = '0;

  // Behavioral copy of the heap and its capacity register.
  timer_slot_t          model_heap [HEAP_SLOTS];
  int unsigned          model_count;
  logic [CFGW-1:0]      model_capacity;

  tmh_pkg::tmh_out_t    result_backlog [$];
  int unsigned          mismatch_count = 0;
  int unsigned          idle_cycles    = 0;
  bit                   steady_flow    = 1'b0;
  logic [TW-1:0]        clock_now      = '0;

  timer_event_min_heap #(
    .HEAP_DEPTH(HEAP_SLOTS),
    .ID_WIDTH  (IDW)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one request to the heap copy and returns the result it yields.
  function automatic tmh_pkg::tmh_out_t heap_step(input tmh_pkg::tmh_in_t req);
    tmh_pkg::tmh_out_t res;
    timer_slot_t       tmp;
    int unsigned       cap;
    int unsigned       pos;
    int unsigned       par;
    int unsigned       best;
    int unsigned       lchild;
    int unsigned       rchild;
    bit                settled;
    res = '0;
    cap = (model_capacity > HEAP_SLOTS) ? HEAP_SLOTS : model_capacity;
    if (req.opcode == tmh_pkg::OP_INSERT) begin
      if (model_count >= cap) begin
        res.status = tmh_pkg::ST_FULL;
      end else begin
        pos = model_count;
        model_heap[pos].start  = req.start_time;
        model_heap[pos].period = req.period;
        model_heap[pos].id     = req.task_id;
        // The new entry climbs while its parent starts strictly later.
        settled = 1'b0;
        while (!settled && pos > 0) begin
          par = (pos - 1) / 2;
          if (model_heap[par].start <= model_heap[pos].start) begin
            settled = 1'b1;
          end else begin
            tmp             = model_heap[par];
            model_heap[par] = model_heap[pos];
            model_heap[pos] = tmp;
            pos             = par;
          end
        end
        model_count = model_count + 1;
        res.status  = tmh_pkg::ST_INSERTED;
      end
    end else if (model_count > 0 && req.current_ticks >= model_heap[0].start) begin
      res.fired_id = model_heap[0].id;
      if (model_heap[0].period != '0) begin
        model_heap[0].start = model_heap[0].start +
                              (model_heap[0].period % tmh_pkg::PERIOD_MOD);
      end else begin
        model_count   = model_count - 1;
        model_heap[0] = model_heap[model_count];
      end
      pos     = 0;
      settled = 1'b0;
      while (!settled && pos < model_count) begin
        best   = pos;
        lchild = 2 * pos + 1;
        rchild = 2 * pos + 2;
        if (lchild < model_count && model_heap[lchild].start < model_heap[best].start) begin
          best = lchild;
        end
        if (rchild < model_count && model_heap[rchild].start < model_heap[best].start) begin
          best = rchild;
        end
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          tmp              = model_heap[pos];
          model_heap[pos]  = model_heap[best];
          model_heap[best] = tmp;
          pos              = best;
        end
      end
      res.status = tmh_pkg::ST_FIRED;
    end else begin
      res.status = tmh_pkg::ST_NONE_DUE;
    end
    res.entry_count_out = model_count[CNTW-1:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  task automatic issue_request(input logic op, input logic [TW-1:0] ticks,
                               input logic [TW-1:0] start, input logic [TW-1:0] per,
                               input logic [IDW-1:0] id);
    tmh_pkg::tmh_in_t req;
    int unsigned      gap;
    req.opcode        = op;
    req.current_ticks = ticks;
    req.start_time    = start;
    req.period        = per;
    req.task_id       = id;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    result_backlog.push_back(heap_step(req));
  endtask

  // Holds off new requests until every result has been taken.
  task automatic wait_heap_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_backlog.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFGW-1:0] value);
    wait_heap_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    model_capacity = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic tick_at(input logic [TW-1:0] ticks);
    issue_request(tmh_pkg::OP_TICK, ticks, TW'($urandom), TW'($urandom), IDW'($urandom));
  endtask

  task automatic test_basic_ops();
    tick_at(16'h0000);
    issue_request(tmh_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    // A period of all ones reloads by zero, so that entry stays at its start.
    issue_request(tmh_pkg::OP_INSERT, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF);
    issue_request(tmh_pkg::OP_INSERT, 16'hFFFF, 16'h0000, 16'h0000, 8'h00);
    issue_request(tmh_pkg::OP_INSERT, 16'h0000, 16'h9000, 16'h8001, 8'h33);
    issue_request(tmh_pkg::OP_INSERT, 16'h0000, 16'h0010, 16'h0000, 8'h55);
    issue_request(tmh_pkg::OP_INSERT, 16'h0000, 16'h0010, 16'h0000, 8'h11);
    issue_request(tmh_pkg::OP_INSERT, 16'h0000, 16'h4000, 16'h4000, 8'hAA);
    tick_at(16'h0000);
    tick_at(16'h000F);
    tick_at(16'h0010);
    tick_at(16'h0010);
    tick_at(16'h4000);
    tick_at(16'h9000);
    // The reload of the 0x33 entry wraps past the top of the time range.
    tick_at(16'h9000);
    tick_at(16'h1001);
    repeat (5) tick_at(16'hFFFF);
  endtask

  task automatic test_capacity_limits();
    set_capacity(6'd0);
    repeat (2) begin
      issue_request(tmh_pkg::OP_INSERT, TW'($urandom), TW'($urandom), 16'h0000,
                    IDW'($urandom));
    end
    tick_at(16'h0000);
    // Anything above the heap depth acts as the depth itself.
    set_capacity(6'd63);
    repeat (34) begin
      issue_request(tmh_pkg::OP_INSERT, TW'($urandom),
                    TW'($urandom_range(16'h2000, 16'hF000)), 16'h0000, IDW'($urandom));
    end
    // Capacity now sits far below the stored count.
    set_capacity(6'd1);
    issue_request(tmh_pkg::OP_INSERT, TW'($urandom), TW'($urandom), 16'h0000,
                  IDW'($urandom));
    repeat (50) tick_at(16'hFFFF);
    set_capacity(6'd5);
    repeat (6) begin
      issue_request(tmh_pkg::OP_INSERT, TW'($urandom), TW'($urandom), 16'h0000,
                    IDW'($urandom));
    end
    repeat (10) tick_at(16'hFFFF);
  endtask

  task automatic run_traffic(input int unsigned count, input int unsigned periodic_pct);
    int unsigned   n;
    int unsigned   roll;
    logic [TW-1:0] start;
    logic [TW-1:0] per;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) begin
        wait_heap_idle();
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        start = ($urandom_range(0, 9) == 0) ? TW'($urandom)
                                            : TW'(clock_now + $urandom_range(0, 400));
        if ($urandom_range(0, 99) < periodic_pct) begin
          per = ($urandom_range(0, 3) == 0) ? TW'($urandom_range(1, 16'hFFFF))
                                            : TW'($urandom_range(1, 300));
        end else begin
          per = '0;
        end
        issue_request(tmh_pkg::OP_INSERT, TW'($urandom), start, per, IDW'($urandom));
      end else if (roll < 90) begin
        if ($urandom_range(0, 99) < 3) begin
          clock_now = TW'(16'hFFFF - $urandom_range(0, 3));
        end else begin
          clock_now = TW'(clock_now + $urandom_range(0, 40));
        end
        tick_at(clock_now);
      end else begin
        issue_request(1'($urandom), TW'($urandom), TW'($urandom), TW'($urandom),
                      IDW'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_capacity(6'd32);
    run_traffic(170, 4);
    steady_flow = 1'b1;
    run_traffic(110, 4);
    steady_flow = 1'b0;
    set_capacity(6'd12);
    run_traffic(150, 4);
    set_capacity(6'd63);
    run_traffic(200, 4);
    set_capacity(6'd32);
    run_traffic(250, 25);
  endtask

  // Receiver: stall stretches between runs of readiness.
  initial begin
    int unsigned hold;
    forever begin
      hold = steady_flow ? 0 : pick_gap();
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tmh_pkg::tmh_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_backlog.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        $display("%0t: result with none awaited, got %p", $time, out_data);
      end else begin
        want = result_backlog.pop_front();
        if (out_data.status !== want.status) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: status expected %0d, got %0d", $time, want.status,
                   out_data.status);
        end
        if (out_data.fired_id !== want.fired_id) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: fired_id expected %0h, got %0h", $time, want.fired_id,
                   out_data.fired_id);
        end
        if (out_data.entry_count_out !== want.entry_count_out) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: entry_count_out expected %0d, got %0d", $time,
                   want.entry_count_out, out_data.entry_count_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    model_count    = 0;
    model_capacity = tmh_pkg::MAX_ENTRIES_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_capacity_limits();
    test_random_traffic();
    wait_heap_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
